/* sv/cursor_list_engine_core_assert.svh */
// Assertion macros for the cursor list engine.
`ifndef CURSOR_LIST_ENGINE_CORE_ASSERT_SVH
`define CURSOR_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define CLE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/cle_pkg.sv */
// Shared types and constants of the cursor list engine.
package cle_pkg;

    localparam int NODES      = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(NODES + 1);
    localparam int ADDR_W     = $clog2(NODES);
    localparam int CNT_W      = 7;
    localparam int ACT_W      = 4;
    localparam int STS_W      = 2;
    localparam int OUT_BITS   = CNT_W + 4 + 3 * VALUE_BITS;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] NIL = IDX_W'(NODES);

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT  = 4'd0,
        ACT_INS_BACK   = 4'd1,
        ACT_INS_BEFORE = 4'd2,
        ACT_INS_AFTER  = 4'd3,
        ACT_DEL_FRONT  = 4'd4,
        ACT_DEL_BACK   = 4'd5,
        ACT_DEL_CURSOR = 4'd6,
        ACT_FIRST      = 4'd7,
        ACT_LAST       = 4'd8,
        ACT_PREV       = 4'd9,
        ACT_NEXT       = 4'd10,
        ACT_CLEAR      = 4'd11,
        ACT_QUERY      = 4'd12
    } act_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK      = 2'd0,
        STS_PRECOND = 2'd1,
        STS_FULL    = 2'd2
    } sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_X,
        S_RD_FH,
        S_EXEC,
        S_WR2,
        S_RD_HEAD,
        S_RD_TAIL,
        S_RD_CUR,
        S_FIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic rd_x;
        logic rd_fh;
        logic exec;
        logic wr2;
        logic rd_head;
        logic rd_tail;
        logic rd_cur;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

/* sv/cursor_list_engine_core.sv */
// Cursor list engine: a doubly linked list of values with one cursor.
// The sequencer walks the node memories one port step a time and takes no new item until the
// result is loaded; it waits to load while the result register is held.
// Reset (rst_n low, asynchronous): empty list, cursor off, empty free chain, no result pending.
// Node memories are not cleared; a clear action restores the reset state in one step.
module cursor_list_engine_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // value[31:0]
    input  logic [3:0]   s_tuser,   // action[3:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // count[6:0], empty_res[7], cursor_off[8], cursor_at_front[9], cursor_at_back[10],
    // front_value[42:11], back_value[74:43], cursor_value[106:75], zero[111:107]
    output logic [111:0] m_tdata,
    output logic [1:0]   m_tuser    // status[1:0]
);
    import cle_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    cle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cle_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_action  (s_tuser),
        .in_value   (s_tdata),
        .out_ready  (m_tready),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

`include "cursor_list_engine_core_assert.svh"

    `CLE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `CLE_ASSERT_NEXT(a_load_shows, cmd.load, m_tvalid, "result not shown after load")
    `CLE_ASSERT_IMPL(a_count_range, m_tvalid, m_tdata[6:0] <= 7'd64, "count above pool size")
    `CLE_ASSERT_IMPL(a_empty_match, m_tvalid, m_tdata[7] == (m_tdata[6:0] == 7'd0), "empty flag")

endmodule

/* sv/cle_ctrl.sv */
// Sequencer of the cursor list engine.
module cle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cle_pkg::dp_stat_t stat,
    output cle_pkg::cmd_t     cmd
);
    import cle_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_RD_X;
            S_RD_X:    state_next = S_RD_FH;
            S_RD_FH:   state_next = S_EXEC;
            S_EXEC:    state_next = S_WR2;
            S_WR2:     state_next = S_RD_HEAD;
            S_RD_HEAD: state_next = S_RD_TAIL;
            S_RD_TAIL: state_next = S_RD_CUR;
            S_RD_CUR:  state_next = S_FIN;
            S_FIN:     if (stat.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_RD_X:    cmd.rd_x    = 1'b1;
            S_RD_FH:   cmd.rd_fh   = 1'b1;
            S_EXEC:    cmd.exec    = 1'b1;
            S_WR2:     cmd.wr2     = 1'b1;
            S_RD_HEAD: cmd.rd_head = 1'b1;
            S_RD_TAIL: cmd.rd_tail = 1'b1;
            S_RD_CUR:  cmd.rd_cur  = 1'b1;
            S_FIN:     cmd.load    = stat.out_free;
            default:   cmd         = '0;
        endcase
    end

endmodule

/* sv/cle_dp.sv */
// Datapath of the cursor list engine: node memories, list registers, result register.
module cle_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cle_pkg::cmd_t                     cmd,
    input  logic [cle_pkg::ACT_W-1:0]         in_action,
    input  logic signed [cle_pkg::VALUE_BITS-1:0] in_value,
    input  logic                              out_ready,
    output cle_pkg::dp_stat_t                 stat,
    output logic                              out_valid,
    output logic [cle_pkg::OUT_W-1:0]         out_data,
    output logic [cle_pkg::STS_W-1:0]         out_status
);
    import cle_pkg::*;

    logic [VALUE_BITS-1:0] mem_val  [NODES];
    logic [IDX_W-1:0]      mem_next [NODES];
    logic [IDX_W-1:0]      mem_prev [NODES];

    logic [VALUE_BITS-1:0] val_q;
    logic [IDX_W-1:0]      next_q;
    logic [IDX_W-1:0]      prev_q;
    logic [IDX_W-1:0]      val_ra, next_ra, prev_ra;

    logic                  val_we, next_we, prev_we;
    logic [IDX_W-1:0]      val_wa, next_wa, prev_wa;
    logic [VALUE_BITS-1:0] val_wd;
    logic [IDX_W-1:0]      next_wd, prev_wd;

    logic [IDX_W-1:0] head_reg, tail_reg, cur_reg, fh_reg, nu_reg;
    logic [IDX_W-1:0] head_next, tail_next, cur_next, fh_next, nu_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [ACT_W-1:0]      act_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [IDX_W-1:0]      x_next_reg, x_prev_reg;
    logic [STS_W-1:0]      sts_reg, sts_next;
    logic [VALUE_BITS-1:0] front_reg, back_reg;

    logic             w2n_en_reg, w2n_en_next, w2p_en_reg, w2p_en_next;
    logic [IDX_W-1:0] w2n_a_reg, w2n_a_next, w2n_d_reg, w2n_d_next;
    logic [IDX_W-1:0] w2p_a_reg, w2p_a_next, w2p_d_reg, w2p_d_next;

    logic                  ex_val_we, ex_next_we, ex_prev_we;
    logic [IDX_W-1:0]      ex_val_wa, ex_next_wa, ex_prev_wa, ex_next_wd, ex_prev_wd;

    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;
    logic [STS_W-1:0]      out_status_reg;

    function automatic logic is_node(input logic [IDX_W-1:0] i);
        return i < NIL;
    endfunction

    // Read ports
    always_comb
    begin
        next_ra = cur_reg;
        prev_ra = cur_reg;
        val_ra  = cur_reg;
        if (cmd.rd_x)
        begin
            case (act_reg)
                ACT_DEL_FRONT: begin next_ra = head_reg; prev_ra = head_reg; end
                ACT_DEL_BACK:  begin next_ra = tail_reg; prev_ra = tail_reg; end
                default:       begin next_ra = cur_reg;  prev_ra = cur_reg;  end
            endcase
        end
        if (cmd.rd_fh)   next_ra = fh_reg;
        if (cmd.rd_head) val_ra  = head_reg;
        if (cmd.rd_tail) val_ra  = tail_reg;
    end

    always_ff @(posedge clk)
    begin
        val_q  <= mem_val[val_ra[ADDR_W-1:0]];
        next_q <= mem_next[next_ra[ADDR_W-1:0]];
        prev_q <= mem_prev[prev_ra[ADDR_W-1:0]];
        if (val_we)  mem_val[val_wa[ADDR_W-1:0]]   <= val_wd;
        if (next_we) mem_next[next_wa[ADDR_W-1:0]] <= next_wd;
        if (prev_we) mem_prev[prev_wa[ADDR_W-1:0]] <= prev_wd;
    end

    // Action logic, evaluated in the execute step
    always_comb
    begin
        logic [IDX_W-1:0] a, b, n;
        logic do_ins, do_del, on;
        a = NIL; b = NIL; n = NIL;
        do_ins = 1'b0; do_del = 1'b0;
        on = is_node(cur_reg);
        head_next = head_reg; tail_next = tail_reg; cur_next = cur_reg;
        fh_next = fh_reg; nu_next = nu_reg; cnt_next = cnt_reg;
        sts_next = STS_OK;
        ex_val_we = 1'b0; ex_next_we = 1'b0; ex_prev_we = 1'b0;
        ex_val_wa = NIL; ex_next_wa = NIL; ex_prev_wa = NIL;
        ex_next_wd = NIL; ex_prev_wd = NIL;
        w2n_en_next = 1'b0; w2n_a_next = NIL; w2n_d_next = NIL;
        w2p_en_next = 1'b0; w2p_a_next = NIL; w2p_d_next = NIL;
        case (act_reg)
            ACT_INS_FRONT:  begin b = head_reg; do_ins = 1'b1; end
            ACT_INS_BACK:   begin a = tail_reg; do_ins = 1'b1; end
            ACT_INS_BEFORE:
                if (on) begin a = x_prev_reg; b = cur_reg; do_ins = 1'b1; end
                else sts_next = STS_PRECOND;
            ACT_INS_AFTER:
                if (on) begin a = cur_reg; b = x_next_reg; do_ins = 1'b1; end
                else sts_next = STS_PRECOND;
            ACT_DEL_FRONT:  begin n = head_reg; do_del = 1'b1; end
            ACT_DEL_BACK:   begin n = tail_reg; do_del = 1'b1; end
            ACT_DEL_CURSOR:
                if (on) begin n = cur_reg; do_del = 1'b1; end
                else sts_next = STS_PRECOND;
            ACT_FIRST:
                if (cnt_reg != '0) cur_next = head_reg;
                else sts_next = STS_PRECOND;
            ACT_LAST:
                if (cnt_reg != '0) cur_next = tail_reg;
                else sts_next = STS_PRECOND;
            ACT_PREV:
                if (on) cur_next = x_prev_reg;
                else sts_next = STS_PRECOND;
            ACT_NEXT:
                if (on) cur_next = x_next_reg;
                else sts_next = STS_PRECOND;
            ACT_CLEAR:
            begin
                head_next = NIL; tail_next = NIL; cur_next = NIL;
                fh_next = NIL; nu_next = '0; cnt_next = '0;
            end
            ACT_QUERY: sts_next = STS_OK;
            default:   sts_next = STS_PRECOND;
        endcase

        if (do_ins)
        begin
            // Take from the free chain first, then from untouched nodes
            if (cnt_reg >= CNT_W'(NODES))
            begin
                sts_next = STS_FULL;
            end
            else if (is_node(fh_reg))
            begin
                n = fh_reg;
                fh_next = next_q;
            end
            else if (nu_reg < NIL)
            begin
                n = nu_reg;
                nu_next = nu_reg + IDX_W'(1);
            end
            else
            begin
                sts_next = STS_FULL;
            end
            if (sts_next == STS_OK)
            begin
                ex_val_we = 1'b1; ex_val_wa = n;
                ex_next_we = 1'b1; ex_next_wa = n; ex_next_wd = b;
                ex_prev_we = 1'b1; ex_prev_wa = n; ex_prev_wd = a;
                if (is_node(a)) begin w2n_en_next = 1'b1; w2n_a_next = a; w2n_d_next = n; end
                else head_next = n;
                if (is_node(b)) begin w2p_en_next = 1'b1; w2p_a_next = b; w2p_d_next = n; end
                else tail_next = n;
                if (cnt_reg == '0) cur_next = n;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end

        if (do_del)
        begin
            if (!is_node(n) || cnt_reg == '0)
            begin
                sts_next = STS_PRECOND;
            end
            else
            begin
                a = x_prev_reg;
                b = x_next_reg;
                if (is_node(a)) begin ex_next_we = 1'b1; ex_next_wa = a; ex_next_wd = b; end
                else head_next = b;
                if (is_node(b)) begin ex_prev_we = 1'b1; ex_prev_wa = b; ex_prev_wd = a; end
                else tail_next = a;
                if (cur_reg == n) cur_next = NIL;
                cnt_next = cnt_reg - CNT_W'(1);
                // return the node to the free chain
                w2n_en_next = 1'b1; w2n_a_next = n; w2n_d_next = fh_reg;
                fh_next = n;
            end
        end
    end

    // Write ports
    always_comb
    begin
        val_we  = cmd.exec & ex_val_we;
        val_wa  = ex_val_wa;
        val_wd  = value_reg;
        next_we = 1'b0; next_wa = ex_next_wa; next_wd = ex_next_wd;
        prev_we = 1'b0; prev_wa = ex_prev_wa; prev_wd = ex_prev_wd;
        if (cmd.exec)
        begin
            next_we = ex_next_we;
            prev_we = ex_prev_we;
        end
        else if (cmd.wr2)
        begin
            next_we = w2n_en_reg; next_wa = w2n_a_reg; next_wd = w2n_d_reg;
            prev_we = w2p_en_reg; prev_wa = w2p_a_reg; prev_wd = w2p_d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= NIL; tail_reg <= NIL; cur_reg <= NIL;
            fh_reg <= NIL; nu_reg <= '0; cnt_reg <= '0;
            w2n_en_reg <= 1'b0; w2p_en_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                head_reg <= head_next; tail_reg <= tail_next; cur_reg <= cur_next;
                fh_reg <= fh_next; nu_reg <= nu_next; cnt_reg <= cnt_next;
                w2n_en_reg <= w2n_en_next; w2p_en_reg <= w2p_en_next;
            end
            if (cmd.load) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg   <= in_action;
            value_reg <= in_value;
        end
        if (cmd.rd_fh)
        begin
            x_next_reg <= next_q;
            x_prev_reg <= prev_q;
        end
        if (cmd.exec)
        begin
            sts_reg   <= sts_next;
            w2n_a_reg <= w2n_a_next; w2n_d_reg <= w2n_d_next;
            w2p_a_reg <= w2p_a_next; w2p_d_reg <= w2p_d_next;
        end
        if (cmd.rd_tail) front_reg <= val_q;
        if (cmd.rd_cur)  back_reg  <= val_q;
        if (cmd.load)
        begin
            out_status_reg <= sts_reg;
            out_data_reg   <= {
                (OUT_W - OUT_BITS)'(0),
                is_node(cur_reg) ? val_q : VALUE_BITS'(0),
                (cnt_reg != '0) ? back_reg : VALUE_BITS'(0),
                (cnt_reg != '0) ? front_reg : VALUE_BITS'(0),
                is_node(cur_reg) && (cur_reg == tail_reg),
                is_node(cur_reg) && (cur_reg == head_reg),
                !is_node(cur_reg),
                cnt_reg == '0,
                cnt_reg
            };
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_status    = out_status_reg;

endmodule
